/* hw/rtl/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg
// shared constants, codes and types of the rational arithmetic unit
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 64;
    localparam int SEXT_SH   = 32 - WORD_BITS;

    localparam logic [WIDE_BITS-1:0] MAXPOS =
        WIDE_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_RED = 3'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_G1_GO,
        S_G1_WT,
        S_D1_GO,
        S_D1_WT,
        S_D2_GO,
        S_D2_WT,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_MP1,
        S_MP2,
        S_ZCHK,
        S_G2_GO,
        S_G2_WT,
        S_D3_GO,
        S_D3_WT,
        S_D4_GO,
        S_D4_WT,
        S_FINCHK,
        S_FIN
    } state_t;

    function automatic logic [31:0] sext_word(input logic [31:0] v);
        logic signed [31:0] s;
        s = signed'(v << SEXT_SH) >>> SEXT_SH;
        return s;
    endfunction

    function automatic logic [31:0] mag_of(input logic [31:0] v);
        logic [31:0] s;
        s = sext_word(v);
        return s[31] ? (~s + 32'd1) : s;
    endfunction

    function automatic logic neg_of(input logic [31:0] v);
        logic [31:0] s;
        s = sext_word(v);
        return s[31];
    endfunction

endpackage

/* hw/rtl/rau_gcd.sv */
// ---------------------------------------------------------------------------
// rau_gcd
// binary gcd of two 64-bit magnitudes, one subtract or shift per cycle
// ---------------------------------------------------------------------------
module rau_gcd (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rau_pkg::WIDE_BITS-1:0]  x,
    input  logic [rau_pkg::WIDE_BITS-1:0]  y,
    output logic                           done,
    output logic [rau_pkg::WIDE_BITS-1:0]  result
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rau_pkg::WIDE_BITS-1:0] x_reg, x_next;
    logic [rau_pkg::WIDE_BITS-1:0] y_reg, y_next;
    logic [5:0]                    k_reg, k_next;
    logic [rau_pkg::WIDE_BITS-1:0] res_reg, res_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = x;
            y_next    = y;
            k_next    = 6'd0;
        end
        else if (busy_reg)
        begin
            if (x_reg == '0 || y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = (x_reg | y_reg) << k_reg;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + 6'd1;
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = x_reg - y_reg;
            end
            else
            begin
                y_next = y_reg - x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* hw/rtl/rau_div.sv */
// ---------------------------------------------------------------------------
// rau_div
// restoring 64-bit divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rau_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rau_pkg::WIDE_BITS-1:0]  dividend,
    input  logic [rau_pkg::WIDE_BITS-1:0]  divisor,
    output logic                           done,
    output logic [rau_pkg::WIDE_BITS-1:0]  quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rau_pkg::WIDE_BITS-1:0] rem_reg, rem_next;
    logic [rau_pkg::WIDE_BITS-1:0] quo_reg, quo_next;
    logic [rau_pkg::WIDE_BITS-1:0] dvs_reg, dvs_next;
    logic [5:0]                    cnt_reg, cnt_next;
    logic [rau_pkg::WIDE_BITS:0]   shifted;
    logic [rau_pkg::WIDE_BITS:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[rau_pkg::WIDE_BITS-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'd0;
        end
        else if (busy_reg)
        begin
            if (!diff[rau_pkg::WIDE_BITS])
            begin
                rem_next = diff[rau_pkg::WIDE_BITS-1:0];
                quo_next = {quo_reg[rau_pkg::WIDE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[rau_pkg::WIDE_BITS-1:0];
                quo_next = {quo_reg[rau_pkg::WIDE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide or reduce fractions with gcd reduction
// ---------------------------------------------------------------------------
// A request carries cmd and two fractions a_num/a_den and b_num/b_den on the
// input channel (in_valid/in_ready); the reduced fraction and a status come
// back on the output channel (out_valid/out_ready), one result per request.
// One request is worked on at a time by a small sequencer that drives a
// binary gcd unit (one subtract or shift per cycle), a restoring 64-bit
// divider and a 32x32 multiplier. Add and subtract run a gcd of the
// denominators, two divisions and three products; multiply and divide run
// two products. Unless the raw numerator is zero, every command then runs a
// gcd of the raw result and two divisions. Errors found on entry go from the
// check straight to the final state. in_ready is high only while the
// sequencer is idle. The result sits in an output register, so a new request
// is taken while an earlier result waits; if the receiver stalls, the next
// result waits in the sequencer until the output register frees up.
// Reset empties the output register and returns the sequencer to idle.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] res_num,
    output logic [30:0] res_den,
    output logic [1:0]  status
);

    localparam int W = rau_pkg::WIDE_BITS;

    rau_pkg::state_t state_reg, state_next;

    logic [2:0]        cmd_reg, cmd_next;
    logic [31:0]       an_reg, an_next;
    logic [31:0]       ad_reg, ad_next;
    logic [31:0]       bn_reg, bn_next;
    logic [31:0]       bd_reg, bd_next;
    logic              an_neg_reg, an_neg_next;
    logic              bn_neg_reg, bn_neg_next;
    logic              rneg_reg, rneg_next;
    logic [W-1:0]      x_reg, x_next;
    logic [W-1:0]      y_reg, y_next;
    logic [W-1:0]      g_reg, g_next;
    logic [31:0]       q1_reg, q1_next;
    logic [31:0]       q2_reg, q2_next;
    logic [W-1:0]      ta_reg, ta_next;
    logic [W-1:0]      tb_reg, tb_next;
    logic [31:0]       fnum_reg, fnum_next;
    logic [30:0]       fden_reg, fden_next;
    rau_pkg::status_t  fst_reg, fst_next;

    logic              ovalid_reg, ovalid_next;
    logic [31:0]       onum_reg, onum_next;
    logic [30:0]       oden_reg, oden_next;
    rau_pkg::status_t  ost_reg, ost_next;

    logic              gcd_start, gcd_done;
    logic [W-1:0]      gcd_x, gcd_y, gcd_res;
    logic              div_start, div_done;
    logic [W-1:0]      div_n, div_d, div_q;
    logic [31:0]       mul_a, mul_b;
    logic [W-1:0]      mul_p;
    logic              out_free, in_fire, bneg, binary, bad;

    assign in_ready = (state_reg == rau_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !ovalid_reg || out_ready;
    assign binary   = (cmd_reg <= rau_pkg::CMD_DIV);
    assign bad      = (ad_reg == '0) || (binary && bd_reg == '0)
                   || (cmd_reg == rau_pkg::CMD_DIV && bn_reg == '0);
    assign bneg     = (cmd_reg == rau_pkg::CMD_SUB) ? !bn_neg_reg : bn_neg_reg;

    rau_gcd u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .x      (gcd_x),
        .y      (gcd_y),
        .done   (gcd_done),
        .result (gcd_res)
    );

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mul_p = W'(mul_a) * W'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE:   if (in_fire) state_next = rau_pkg::S_CHECK;
            rau_pkg::S_CHECK:
            begin
                if (bad)
                    state_next = rau_pkg::S_FIN;
                else if (cmd_reg == rau_pkg::CMD_ADD || cmd_reg == rau_pkg::CMD_SUB)
                    state_next = rau_pkg::S_G1_GO;
                else if (binary)
                    state_next = rau_pkg::S_MP1;
                else
                    state_next = rau_pkg::S_ZCHK;
            end
            rau_pkg::S_G1_GO:  state_next = rau_pkg::S_G1_WT;
            rau_pkg::S_G1_WT:  if (gcd_done) state_next = rau_pkg::S_D1_GO;
            rau_pkg::S_D1_GO:  state_next = rau_pkg::S_D1_WT;
            rau_pkg::S_D1_WT:  if (div_done) state_next = rau_pkg::S_D2_GO;
            rau_pkg::S_D2_GO:  state_next = rau_pkg::S_D2_WT;
            rau_pkg::S_D2_WT:  if (div_done) state_next = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1:   state_next = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:   state_next = rau_pkg::S_MUL3;
            rau_pkg::S_MUL3:   state_next = rau_pkg::S_COMB;
            rau_pkg::S_COMB:   state_next = rau_pkg::S_ZCHK;
            rau_pkg::S_MP1:    state_next = rau_pkg::S_MP2;
            rau_pkg::S_MP2:    state_next = rau_pkg::S_ZCHK;
            rau_pkg::S_ZCHK:
                state_next = (x_reg == '0) ? rau_pkg::S_FIN : rau_pkg::S_G2_GO;
            rau_pkg::S_G2_GO:  state_next = rau_pkg::S_G2_WT;
            rau_pkg::S_G2_WT:  if (gcd_done) state_next = rau_pkg::S_D3_GO;
            rau_pkg::S_D3_GO:  state_next = rau_pkg::S_D3_WT;
            rau_pkg::S_D3_WT:  if (div_done) state_next = rau_pkg::S_D4_GO;
            rau_pkg::S_D4_GO:  state_next = rau_pkg::S_D4_WT;
            rau_pkg::S_D4_WT:  if (div_done) state_next = rau_pkg::S_FINCHK;
            rau_pkg::S_FINCHK: state_next = rau_pkg::S_FIN;
            rau_pkg::S_FIN:    if (out_free) state_next = rau_pkg::S_IDLE;
            default:           state_next = rau_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        an_neg_next = an_neg_reg;
        bn_neg_next = bn_neg_reg;
        rneg_next   = rneg_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        g_next      = g_reg;
        q1_next     = q1_reg;
        q2_next     = q2_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        fnum_next   = fnum_reg;
        fden_next   = fden_reg;
        fst_next    = fst_reg;
        ovalid_next = ovalid_reg && !out_ready;
        onum_next   = onum_reg;
        oden_next   = oden_reg;
        ost_next    = ost_reg;
        gcd_start   = 1'b0;
        gcd_x       = x_reg;
        gcd_y       = y_reg;
        div_start   = 1'b0;
        div_n       = x_reg;
        div_d       = g_reg;
        mul_a       = an_reg;
        mul_b       = bn_reg;
        unique case (state_reg)
            rau_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next    = cmd;
                    an_next     = rau_pkg::mag_of(a_num);
                    ad_next     = rau_pkg::mag_of(a_den);
                    bn_next     = rau_pkg::mag_of(b_num);
                    bd_next     = rau_pkg::mag_of(b_den);
                    an_neg_next = rau_pkg::neg_of(a_num) ^ rau_pkg::neg_of(a_den);
                    bn_neg_next = rau_pkg::neg_of(b_num) ^ rau_pkg::neg_of(b_den);
                end
            end
            rau_pkg::S_CHECK:
            begin
                fnum_next = 32'd0;
                fden_next = 31'd1;
                fst_next  = bad ? rau_pkg::ST_ZERO : rau_pkg::ST_OK;
                rneg_next = binary ? (an_neg_reg ^ bn_neg_reg) : an_neg_reg;
                x_next    = W'(an_reg);
                y_next    = W'(ad_reg);
            end
            rau_pkg::S_G1_GO:
            begin
                gcd_start = 1'b1;
                gcd_x     = W'(ad_reg);
                gcd_y     = W'(bd_reg);
            end
            rau_pkg::S_G1_WT:  if (gcd_done) g_next = gcd_res;
            rau_pkg::S_D1_GO:
            begin
                div_start = 1'b1;
                div_n     = W'(ad_reg);
            end
            rau_pkg::S_D1_WT:  if (div_done) q1_next = div_q[31:0];
            rau_pkg::S_D2_GO:
            begin
                div_start = 1'b1;
                div_n     = W'(bd_reg);
            end
            rau_pkg::S_D2_WT:  if (div_done) q2_next = div_q[31:0];
            rau_pkg::S_MUL1:
            begin
                mul_a  = q1_reg;
                mul_b  = bd_reg;
                y_next = mul_p;
            end
            rau_pkg::S_MUL2:
            begin
                mul_a   = an_reg;
                mul_b   = q2_reg;
                ta_next = mul_p;
            end
            rau_pkg::S_MUL3:
            begin
                mul_a   = bn_reg;
                mul_b   = q1_reg;
                tb_next = mul_p;
            end
            rau_pkg::S_COMB:
            begin
                if (an_neg_reg == bneg)
                begin
                    rneg_next = an_neg_reg;
                    x_next    = ta_reg + tb_reg;
                end
                else if (ta_reg >= tb_reg)
                begin
                    rneg_next = an_neg_reg;
                    x_next    = ta_reg - tb_reg;
                end
                else
                begin
                    rneg_next = bneg;
                    x_next    = tb_reg - ta_reg;
                end
            end
            rau_pkg::S_MP1:
            begin
                mul_a  = an_reg;
                mul_b  = (cmd_reg == rau_pkg::CMD_MUL) ? bn_reg : bd_reg;
                x_next = mul_p;
            end
            rau_pkg::S_MP2:
            begin
                mul_a  = ad_reg;
                mul_b  = (cmd_reg == rau_pkg::CMD_MUL) ? bd_reg : bn_reg;
                y_next = mul_p;
            end
            rau_pkg::S_ZCHK:
            begin
                fnum_next = 32'd0;
                fden_next = 31'd1;
                fst_next  = rau_pkg::ST_OK;
            end
            rau_pkg::S_G2_GO:  gcd_start = 1'b1;
            rau_pkg::S_G2_WT:  if (gcd_done) g_next = gcd_res;
            rau_pkg::S_D3_GO:  div_start = 1'b1;
            rau_pkg::S_D3_WT:  if (div_done) x_next = div_q;
            rau_pkg::S_D4_GO:
            begin
                div_start = 1'b1;
                div_n     = y_reg;
            end
            rau_pkg::S_D4_WT:  if (div_done) y_next = div_q;
            rau_pkg::S_FINCHK:
            begin
                if ((y_reg > rau_pkg::MAXPOS)
                    || (rneg_reg ? (x_reg > rau_pkg::MAXPOS + W'(1))
                                 : (x_reg > rau_pkg::MAXPOS)))
                begin
                    fnum_next = 32'd0;
                    fden_next = 31'd1;
                    fst_next  = rau_pkg::ST_OVF;
                end
                else
                begin
                    fnum_next = rneg_reg ? (32'd0 - x_reg[31:0]) : x_reg[31:0];
                    fden_next = y_reg[30:0];
                    fst_next  = rau_pkg::ST_OK;
                end
            end
            rau_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    onum_next   = fnum_reg;
                    oden_next   = fden_reg;
                    ost_next    = fst_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rau_pkg::S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        an_neg_reg <= an_neg_next;
        bn_neg_reg <= bn_neg_next;
        rneg_reg   <= rneg_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        g_reg      <= g_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        fnum_reg   <= fnum_next;
        fden_reg   <= fden_next;
        fst_reg    <= fst_next;
        onum_reg   <= onum_next;
        oden_reg   <= oden_next;
        ost_reg    <= ost_next;
    end

    assign out_valid = ovalid_reg;
    assign res_num   = onum_reg;
    assign res_den   = oden_reg;
    assign status    = ost_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != rau_pkg::ST_OK |-> res_num == 32'd0 && res_den == 31'd1)
        else $error("error result is not 0/1");
    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> res_den != 31'd0)
        else $error("zero result denominator");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");
`endif

endmodule
